// ===== hw/rtl/sts_pkg.sv =====
// Shared types, token codes, character constants and keyword table of the SQL token scanner.
`default_nettype none

package sts_pkg;

  localparam int unsigned OFFSET_WIDTH_DEF  = 16;
  localparam int unsigned KEYWORD_CHARS_DEF = 8;

  // Token queue: power-of-two depth, at most MAX_TOKENS pushed per transfer.
  localparam int unsigned TOKQ_DEPTH = 8;
  localparam int unsigned MAX_TOKENS = 3;
  localparam int unsigned NUM_CAND   = 4;

  localparam int unsigned NUM_KW     = 22;
  localparam int unsigned KW_MAX_LEN = 8;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_STRING,
    MODE_HELD
  } scan_mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  // Token kinds
  localparam logic [5:0] K_END     = 6'd0;
  localparam logic [5:0] K_ILLEGAL = 6'd1;
  localparam logic [5:0] K_IDENT   = 6'd2;
  localparam logic [5:0] K_INT     = 6'd3;
  localparam logic [5:0] K_FLOAT   = 6'd4;
  localparam logic [5:0] K_STRING  = 6'd5;
  localparam logic [5:0] K_COMMA   = 6'd6;
  localparam logic [5:0] K_STAR    = 6'd7;
  localparam logic [5:0] K_LPAREN  = 6'd8;
  localparam logic [5:0] K_RPAREN  = 6'd9;
  localparam logic [5:0] K_PLUS    = 6'd10;
  localparam logic [5:0] K_MINUS   = 6'd11;
  localparam logic [5:0] K_SEMI    = 6'd12;
  localparam logic [5:0] K_EQUAL   = 6'd13;
  localparam logic [5:0] K_NOTEQ   = 6'd14;
  localparam logic [5:0] K_LE      = 6'd15;
  localparam logic [5:0] K_GE      = 6'd16;
  localparam logic [5:0] K_ASSIGN  = 6'd17;
  localparam logic [5:0] K_DOT     = 6'd18;
  localparam logic [5:0] K_SLASH   = 6'd19;
  localparam logic [5:0] K_PERCENT = 6'd20;
  localparam logic [5:0] K_KW0     = 6'd21;

  // Character codes
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // Keyword text, right-justified as string literals, in kind order.
  localparam logic [63:0] KW_RAW [NUM_KW] = '{
    "create", "table", "insert", "into", "delete", "drop", "select", "from",
    "where", "and", "or", "not", "in", "is", "null", "if",
    "exists", "true", "false", "between", "distinct", "all"
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd6, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd6, 4'd4,
    4'd5, 4'd3, 4'd2, 4'd3, 4'd2, 4'd2, 4'd4, 4'd2,
    4'd6, 4'd4, 4'd5, 4'd7, 4'd8, 4'd3
  };

  // Keyword with its first character in the lowest byte, zero padded.
  function automatic logic [63:0] kw_aligned(int k);
    logic [63:0] r;
    int          l;
    r = '0;
    l = int'(KW_LEN[k]);
    for (int j = 0; j < KW_MAX_LEN; j++) begin
      if (j < l) r[8*j +: 8] = KW_RAW[k][8*(l-1-j) +: 8];
    end
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'h20 : c;
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      CH_COMMA:   k = K_COMMA;
      CH_STAR:    k = K_STAR;
      CH_LPAREN:  k = K_LPAREN;
      CH_RPAREN:  k = K_RPAREN;
      CH_PLUS:    k = K_PLUS;
      CH_MINUS:   k = K_MINUS;
      CH_SEMI:    k = K_SEMI;
      CH_EQ:      k = K_ASSIGN;
      CH_DOT:     k = K_DOT;
      CH_SLASH:   k = K_SLASH;
      CH_PERCENT: k = K_PERCENT;
      default:    k = K_ILLEGAL;
    endcase
    return k;
  endfunction

  // Two-character operator kind, K_END when the pair is no operator.
  function automatic logic [5:0] pair_kind(logic [7:0] a, logic [7:0] b);
    logic [5:0] k;
    priority if (a == CH_EQ && b == CH_EQ)     k = K_EQUAL;
    else if (a == CH_BANG && b == CH_EQ)       k = K_NOTEQ;
    else if (a == CH_LT && b == CH_GT)         k = K_NOTEQ;
    else if (a == CH_LT && b == CH_EQ)         k = K_LE;
    else if (a == CH_GT && b == CH_EQ)         k = K_GE;
    else                                       k = K_END;
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sts_kw_match.sv =====
// Parallel compare of a folded word against the keyword table.
`default_nettype none

module sts_kw_match #(
  parameter int unsigned KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEF
) (
  input  logic [KEYWORD_CHARS-1:0][7:0] word_i,
  input  logic [15:0]                   len_i,
  output logic [5:0]                    kind_o
);
  import sts_pkg::*;

  logic [NUM_KW-1:0] hit;

  for (genvar k = 0; k < NUM_KW; k++) begin : g_kw
    localparam logic [63:0] KwText = kw_aligned(k);
    // Bytes past the word length are zero, so the padded text compares whole.
    assign hit[k] = (len_i == 16'(KW_LEN[k])) && (word_i[KW_MAX_LEN-1:0] == KwText);
  end

  always_comb begin
    kind_o = K_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (hit[k]) kind_o = K_KW0 + 6'(k);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sts_scan_core.sv =====
// Scanner state and per-byte token decision, up to four candidate tokens per transfer.
`default_nettype none

module sts_scan_core #(
  parameter int unsigned OFFSET_WIDTH  = sts_pkg::OFFSET_WIDTH_DEF,
  parameter int unsigned KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             char_i,
  input  logic                   last_i,
  output sts_pkg::token_t        tok_o [sts_pkg::NUM_CAND],
  output logic [sts_pkg::NUM_CAND-1:0] tok_valid_o
);
  import sts_pkg::*;

  localparam logic [OFFSET_WIDTH-1:0] OffOne = OFFSET_WIDTH'(1);

  scan_mode_e                    mode_q, mode_s, mode_d;
  logic [7:0]                    held_q, held_s;
  logic [KEYWORD_CHARS-1:0][7:0] wbuf_q, wbuf_s;
  logic [15:0]                   len_q, len_s;
  logic [1:0]                    dots_q, dots_s;
  logic [OFFSET_WIDTH-1:0]       start_q, start_s;
  logic [OFFSET_WIDTH-1:0]       off_q, off_d, off_inc;
  logic                          bs_q, bs_s, bs_d;

  logic [5:0] kw_cur, kw_nxt;
  logic       do_start;
  token_t     flush_cur, flush_nxt;

  // Tokens of the byte itself and tokens of the end of text.
  token_t     step_tok [2];
  logic [1:0] step_valid;
  token_t     end_tok  [2];
  logic [1:0] end_valid;

  sts_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw_cur (
    .word_i(wbuf_q), .len_i(len_q), .kind_o(kw_cur)
  );

  sts_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw_nxt (
    .word_i(wbuf_s), .len_i(len_s), .kind_o(kw_nxt)
  );

  function automatic token_t flush_tok(scan_mode_e m, logic [7:0] h, logic [5:0] kwk,
                                       logic [15:0] len, logic [1:0] d,
                                       logic [OFFSET_WIDTH-1:0] st);
    token_t                  t;
    logic [OFFSET_WIDTH-1:0] quote_pos;
    quote_pos = st - OffOne;
    t.kind    = K_ILLEGAL;
    t.start   = 16'(st);
    t.length  = len;
    t.last    = 1'b0;
    unique case (m)
      MODE_WORD:   t.kind = kwk;
      MODE_NUMBER: t.kind = (d == 2'd0) ? K_INT : ((d == 2'd1) ? K_FLOAT : K_ILLEGAL);
      MODE_HELD: begin
        t.kind   = single_kind(h);
        t.length = 16'd1;
      end
      MODE_STRING: begin
        t.start  = 16'(quote_pos);
        t.length = sat_inc(len);
      end
      default: ;
    endcase
    return t;
  endfunction

  assign flush_cur = flush_tok(mode_q, held_q, kw_cur, len_q, dots_q, start_q);
  assign off_inc   = off_q + OffOne;

  // Step on the byte itself.
  always_comb begin
    mode_s   = mode_q;
    held_s   = held_q;
    wbuf_s   = wbuf_q;
    len_s    = len_q;
    dots_s   = dots_q;
    start_s  = start_q;
    bs_s     = bs_q;
    do_start = 1'b0;
    step_valid[0] = 1'b0;
    step_valid[1] = 1'b0;
    step_tok[0] = flush_cur;
    step_tok[1] = '{kind: single_kind(char_i), start: 16'(off_q), length: 16'd1, last: 1'b0};

    unique case (mode_q)
      MODE_WORD: begin
        if (is_alpha(char_i) || is_digit(char_i) || char_i == CH_UNDER) begin
          for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (len_q == 16'(i)) wbuf_s[i] = to_lower(char_i);
          end
          len_s = sat_inc(len_q);
        end else begin
          step_valid[0] = 1'b1;
          do_start      = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(char_i) || char_i == CH_DOT) begin
          if (char_i == CH_DOT && dots_q != 2'd2) dots_s = dots_q + 2'd1;
          len_s = sat_inc(len_q);
        end else begin
          step_valid[0] = 1'b1;
          do_start      = 1'b1;
        end
      end
      MODE_STRING: begin
        if (char_i == CH_QUOTE && !bs_q) begin
          step_valid[0]      = 1'b1;
          step_tok[0].kind   = K_STRING;
          step_tok[0].start  = 16'(start_q);
          step_tok[0].length = len_q;
          mode_s = MODE_IDLE;
        end else begin
          len_s = sat_inc(len_q);
          bs_s  = (char_i == CH_BSLASH);
        end
      end
      MODE_HELD: begin
        step_valid[0] = 1'b1;
        if (pair_kind(held_q, char_i) != K_END) begin
          step_tok[0].kind   = pair_kind(held_q, char_i);
          step_tok[0].length = 16'd2;
          mode_s = MODE_IDLE;
        end else begin
          do_start = 1'b1;
        end
      end
      default: do_start = 1'b1;
    endcase

    if (do_start) begin
      mode_s = MODE_IDLE;
      priority if (is_space(char_i)) begin
        mode_s = MODE_IDLE;
      end else if (is_digit(char_i)) begin
        mode_s  = MODE_NUMBER;
        start_s = off_q;
        len_s   = 16'd1;
        dots_s  = 2'd0;
      end else if (is_alpha(char_i)) begin
        wbuf_s    = '0;
        wbuf_s[0] = to_lower(char_i);
        mode_s    = MODE_WORD;
        start_s   = off_q;
        len_s     = 16'd1;
      end else if (char_i == CH_QUOTE) begin
        mode_s  = MODE_STRING;
        start_s = off_inc;
        len_s   = 16'd0;
        bs_s    = 1'b0;
      end else if (char_i == CH_EQ || char_i == CH_BANG || char_i == CH_LT ||
                   char_i == CH_GT) begin
        mode_s  = MODE_HELD;
        held_s  = char_i;
        start_s = off_q;
      end else begin
        step_valid[1] = 1'b1;
      end
    end
  end

  assign flush_nxt = flush_tok(mode_s, held_s, kw_nxt, len_s, dots_s, start_s);

  // End of text: flush what the byte left open, then close with the end token.
  always_comb begin
    mode_d = mode_s;
    off_d  = off_inc;
    bs_d   = bs_s;
    end_valid[0] = 1'b0;
    end_valid[1] = 1'b0;
    end_tok[0] = flush_nxt;
    end_tok[1] = '{kind: K_END, start: 16'(off_inc), length: 16'd0, last: 1'b1};
    if (last_i) begin
      end_valid[0] = (mode_s != MODE_IDLE);
      end_valid[1] = 1'b1;
      mode_d = MODE_IDLE;
      off_d  = '0;
      bs_d   = 1'b0;
    end
  end

  assign tok_o[0]    = step_tok[0];
  assign tok_o[1]    = step_tok[1];
  assign tok_o[2]    = end_tok[0];
  assign tok_o[3]    = end_tok[1];
  assign tok_valid_o = {end_valid, step_valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      held_q  <= '0;
      wbuf_q  <= '0;
      len_q   <= '0;
      dots_q  <= '0;
      start_q <= '0;
      off_q   <= '0;
      bs_q    <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      held_q  <= held_s;
      wbuf_q  <= wbuf_s;
      len_q   <= len_s;
      dots_q  <= dots_s;
      start_q <= start_s;
      off_q   <= off_d;
      bs_q    <= bs_d;
    end
  end

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> mode_q == MODE_IDLE && off_q == '0)
    else $error("scanner not idle after end of text");

  a_max_tokens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> $countones(tok_valid_o) <= MAX_TOKENS)
    else $error("more tokens than the queue reserves");

  a_offset_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !last_i |=> off_q == $past(off_q) + OffOne)
    else $error("byte offset did not advance");

endmodule

`default_nettype wire

// ===== hw/rtl/sts_tok_fifo.sv =====
// Token queue: up to three tokens in per push, one out per cycle while ready.
`default_nettype none

module sts_tok_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  sts_pkg::token_t               tok_i [sts_pkg::NUM_CAND],
  input  logic [sts_pkg::NUM_CAND-1:0]  tok_valid_i,
  output logic                          room_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sts_pkg::token_t               out_tok_o
);
  import sts_pkg::*;

  localparam int unsigned PtrW = $clog2(TOKQ_DEPTH);
  localparam int unsigned CntW = $clog2(TOKQ_DEPTH + 1);

  token_t            mem_q [TOKQ_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [2:0]        pos   [NUM_CAND];
  logic [2:0]        n_push;
  logic              pop;

  always_comb begin
    n_push = 3'd0;
    for (int i = 0; i < NUM_CAND; i++) begin
      pos[i] = n_push;
      if (push_i && tok_valid_i[i]) n_push = n_push + 3'd1;
    end
  end

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_tok_o   = mem_q[rd_q];
  assign room_o      = (cnt_q <= CntW'(TOKQ_DEPTH - MAX_TOKENS));

  assign wr_d  = wr_q + PtrW'(n_push);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + CntW'(n_push) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_CAND; i++) begin
      if (push_i && tok_valid_i[i]) mem_q[wr_q + PtrW'(pos[i])] <= tok_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TOKQ_DEPTH))
    else $error("token queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("push without reserved room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && n_push == 3'd0 |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("queue count off after pop");

endmodule

`default_nettype wire

// ===== hw/rtl/sql_token_scanner_top.sv =====
// Top level of the SQL token scanner: byte stream in, token stream out.
//
// Slave stream: one text byte per transfer in s_axis_tdata[7:0]; s_axis_tlast
// marks the last byte of a statement. Master stream: one token per transfer,
// m_axis_tdata = {pad, length, start, kind}, m_axis_tlast on the end token.
// A byte yields zero to three tokens (a flushed run, a one-byte symbol, the
// end token). Tokens of a byte are written to an 8-entry queue at the edge
// that takes the byte and are handed out in order; the master side sends
// one token per cycle while m_axis_tready is high. Throughput is one byte
// per cycle while s_axis_tready is high, that is while the queue has room
// for three more tokens; a slow receiver stalls the input once fewer are free.
// Reset clears the scanner to idle with offset zero and empties the queue.
// After an end token the offset restarts at zero for the next statement.
`default_nettype none

module sql_token_scanner_top #(
  parameter int unsigned OFFSET_WIDTH  = sts_pkg::OFFSET_WIDTH_DEF,
  parameter int unsigned KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [5:0] token_kind, [21:6] token_start,
                                      // [37:22] token_length, [39:38] zero
  output logic        m_axis_tlast    // last_token
);
  import sts_pkg::*;

  logic                accept;
  logic                room;
  token_t              cand     [NUM_CAND];
  logic [NUM_CAND-1:0] cand_valid;
  token_t              out_tok;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  sts_scan_core #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .char_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .tok_o      (cand),
    .tok_valid_o(cand_valid)
  );

  sts_tok_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .tok_i      (cand),
    .tok_valid_i(cand_valid),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_tok_o  (out_tok)
  );

  assign m_axis_tdata = {2'b00, out_tok.length, out_tok.start, out_tok.kind};
  assign m_axis_tlast = out_tok.last;

endmodule

`default_nettype wire
